/* sv/porm_pkg.sv */
// Package for the placement optimal region median unit.
// Holds sizing constants, shared types, the controller state encoding and helpers.
// Has no dependencies; the interfaces and the median unit use it.
package porm_pkg;

    // Sizing of the net store and of coordinates.
    localparam int MAX_NETS   = 32;
    localparam int COORD_BITS = 10;

    // Fixed widths of the port fields.
    localparam int FIELD_W = 10;
    localparam int HPWL_W  = 16;

    // Derived widths.
    localparam int NET_AW   = (MAX_NETS > 1) ? $clog2(MAX_NETS) : 1;
    localparam int CNT_W    = $clog2(MAX_NETS + 1);
    localparam int RANK_W   = CNT_W + 1;
    localparam int BIT_W    = $clog2(COORD_BITS);
    localparam int ROW_W    = 2 * COORD_BITS;
    localparam int HSUM_W   = HPWL_W + 1;
    localparam int NUM_SEL  = 4;

    // Selector slots: lower and upper median of x, then of y.
    localparam int SEL_X_LO = 0;
    localparam int SEL_X_HI = 1;
    localparam int SEL_Y_LO = 2;
    localparam int SEL_Y_HI = 3;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [FIELD_W-1:0]    field_t;
    typedef logic [HPWL_W-1:0]     hpwl_t;
    typedef logic [HSUM_W-1:0]     hsum_t;
    typedef logic [COORD_BITS:0]   span_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [RANK_W-1:0]     rank_t;
    typedef logic [BIT_W-1:0]      bit_idx_t;
    typedef logic [NET_AW-1:0]     net_addr_t;
    typedef logic [ROW_W-1:0]      row_t;

    // Bounding box held in registers while a net streams in.
    typedef struct packed {
        coord_t xmin;
        coord_t xmax;
        coord_t ymin;
        coord_t ymax;
    } box_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_SEL_READ,
        ST_SEL_LAST,
        ST_SEL_RESOLVE,
        ST_FINISH
    } state_t;

    // Box with no pin: minimum at the coordinate maximum, maximum at zero.
    localparam box_t BOX_EMPTY = '{xmin: '1, xmax: '0, ymin: '1, ymax: '0};

    // Port field to internal coordinate: keep the low COORD_BITS bits.
    function automatic coord_t to_coord(field_t v);
        return coord_t'(v);
    endfunction

    // Internal coordinate to port field.
    function automatic field_t to_field(coord_t c);
        return field_t'(c);
    endfunction

endpackage

/* sv/porm_if.sv */
// Handshake channels of the placement optimal region median unit.
// Pin words flow in, region words flow out; both use valid and ready.
// Depends on porm_pkg for the field types.
interface porm_pin_if;
    logic              valid;
    logic              ready;
    porm_pkg::field_t  pin_x;
    porm_pkg::field_t  pin_y;
    logic              is_moving_cell;
    logic              last_pin_of_net;
    logic              last_net;

    modport source (
        output valid, pin_x, pin_y, is_moving_cell, last_pin_of_net, last_net,
        input  ready
    );
    modport sink (
        input  valid, pin_x, pin_y, is_moving_cell, last_pin_of_net, last_net,
        output ready
    );
endinterface

interface porm_region_if;
    logic              valid;
    logic              ready;
    porm_pkg::field_t  left_bound;
    porm_pkg::field_t  right_bound;
    porm_pkg::field_t  top_bound;
    porm_pkg::field_t  bottom_bound;
    porm_pkg::hpwl_t   hpwl_total;
    logic              empty_net_seen;
    logic              net_overflow;

    modport source (
        output valid, left_bound, right_bound, top_bound, bottom_bound,
               hpwl_total, empty_net_seen, net_overflow,
        input  ready
    );
    modport sink (
        input  valid, left_bound, right_bound, top_bound, bottom_bound,
               hpwl_total, empty_net_seen, net_overflow,
        output ready
    );
endinterface

/* sv/placement_optimal_region_median_unit.sv */
// Optimal region finder: pins are taken only while collecting; a word with last_net set
// starts a radix selection that makes COORD_BITS passes over the n stored net rows,
// each pass reading them through the single read port of each bound store.
// The region word is loaded in the finish state once the output register is free.
// Pins of the next cell are taken again once the region word is loaded.
// Asynchronous active-low reset empties the boxes and clears counts and flags.
module placement_optimal_region_median_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    porm_pin_if.sink             pins,
    porm_region_if.source        region
);

    // Controller and accumulation state.
    porm_pkg::state_t    state_reg, state_next;
    porm_pkg::box_t      excl_reg, excl_next;
    porm_pkg::box_t      full_reg, full_next;
    porm_pkg::cnt_t      net_count_reg, net_count_next;
    porm_pkg::hpwl_t     hpwl_reg, hpwl_next;
    logic                empty_reg, empty_next;
    logic                ovf_reg, ovf_next;

    // Selection state.
    porm_pkg::cnt_t      rd_idx_reg, rd_idx_next;
    logic                rd_valid_reg;
    porm_pkg::bit_idx_t  bit_reg, bit_next;
    porm_pkg::coord_t    prefix_reg [porm_pkg::NUM_SEL];
    porm_pkg::coord_t    prefix_next [porm_pkg::NUM_SEL];
    porm_pkg::rank_t     rank_reg [porm_pkg::NUM_SEL];
    porm_pkg::rank_t     rank_next [porm_pkg::NUM_SEL];
    porm_pkg::rank_t     count_reg [porm_pkg::NUM_SEL];
    porm_pkg::rank_t     count_next [porm_pkg::NUM_SEL];

    // Output register.
    logic                out_valid_reg, out_valid_next;
    porm_pkg::field_t    left_reg, right_reg, top_reg, bottom_reg;
    porm_pkg::hpwl_t     hpwl_out_reg;
    logic                empty_out_reg, ovf_out_reg;

    // Decoded controls.
    logic                in_ready;
    logic                rd_en;
    logic                load_out;
    logic                accept;
    logic                close_net;
    logic                room;
    logic                wr_en;
    logic                last_row;
    porm_pkg::coord_t    pin_x_c, pin_y_c;
    porm_pkg::box_t      excl_pin, full_pin;
    porm_pkg::span_t     span;
    porm_pkg::hsum_t     hpwl_sum;
    porm_pkg::row_t      x_wr_row, y_wr_row, x_rd_row, y_rd_row;
    porm_pkg::coord_t    bit_m, low_m, high_m;

    // Bound stores: each row holds {max, min} of one net's box without the cell.
    porm_ram #(
        .WIDTH (porm_pkg::ROW_W),
        .DEPTH (porm_pkg::MAX_NETS)
    ) u_x_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (net_count_reg[porm_pkg::NET_AW-1:0]),
        .wr_data (x_wr_row),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[porm_pkg::NET_AW-1:0]),
        .rd_data (x_rd_row)
    );

    porm_ram #(
        .WIDTH (porm_pkg::ROW_W),
        .DEPTH (porm_pkg::MAX_NETS)
    ) u_y_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (net_count_reg[porm_pkg::NET_AW-1:0]),
        .wr_data (y_wr_row),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[porm_pkg::NET_AW-1:0]),
        .rd_data (y_rd_row)
    );

    // Pin word handling and box update including the current pin.
    assign accept    = pins.valid && in_ready;
    assign close_net = accept && (pins.last_pin_of_net || pins.last_net);
    assign room      = net_count_reg < porm_pkg::cnt_t'(porm_pkg::MAX_NETS);
    assign wr_en     = close_net && room;
    assign pin_x_c   = porm_pkg::to_coord(pins.pin_x);
    assign pin_y_c   = porm_pkg::to_coord(pins.pin_y);
    assign last_row  = (rd_idx_reg + porm_pkg::cnt_t'(1)) == net_count_reg;

    always_comb
    begin
        full_pin.xmin = (pin_x_c < full_reg.xmin) ? pin_x_c : full_reg.xmin;
        full_pin.xmax = (pin_x_c > full_reg.xmax) ? pin_x_c : full_reg.xmax;
        full_pin.ymin = (pin_y_c < full_reg.ymin) ? pin_y_c : full_reg.ymin;
        full_pin.ymax = (pin_y_c > full_reg.ymax) ? pin_y_c : full_reg.ymax;
        excl_pin      = excl_reg;
        if (!pins.is_moving_cell)
        begin
            excl_pin.xmin = (pin_x_c < excl_reg.xmin) ? pin_x_c : excl_reg.xmin;
            excl_pin.xmax = (pin_x_c > excl_reg.xmax) ? pin_x_c : excl_reg.xmax;
            excl_pin.ymin = (pin_y_c < excl_reg.ymin) ? pin_y_c : excl_reg.ymin;
            excl_pin.ymax = (pin_y_c > excl_reg.ymax) ? pin_y_c : excl_reg.ymax;
        end
    end

    assign x_wr_row = {excl_pin.xmax, excl_pin.xmin};
    assign y_wr_row = {excl_pin.ymax, excl_pin.ymin};

    // Half perimeter of the closing net's full box, added with saturation.
    assign span     = porm_pkg::span_t'(full_pin.xmax - full_pin.xmin)
                    + porm_pkg::span_t'(full_pin.ymax - full_pin.ymin);
    assign hpwl_sum = porm_pkg::hsum_t'(hpwl_reg) + porm_pkg::hsum_t'(span);

    // Masks for the bit under decision and the bits already decided above it.
    assign bit_m  = porm_pkg::coord_t'(1) << bit_reg;
    assign low_m  = bit_m - porm_pkg::coord_t'(1);
    assign high_m = ~(bit_m | low_m);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            porm_pkg::ST_COLLECT:
            begin
                if (accept && pins.last_net)
                begin
                    state_next = porm_pkg::ST_SEL_READ;
                end
            end
            porm_pkg::ST_SEL_READ:
            begin
                if (last_row)
                begin
                    state_next = porm_pkg::ST_SEL_LAST;
                end
            end
            porm_pkg::ST_SEL_LAST:
            begin
                state_next = porm_pkg::ST_SEL_RESOLVE;
            end
            porm_pkg::ST_SEL_RESOLVE:
            begin
                if (bit_reg == '0)
                begin
                    state_next = porm_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = porm_pkg::ST_SEL_READ;
                end
            end
            porm_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || region.ready)
                begin
                    state_next = porm_pkg::ST_COLLECT;
                end
            end
            default:
            begin
                state_next = porm_pkg::ST_COLLECT;
            end
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg) inside
            porm_pkg::ST_COLLECT:
            begin
                in_ready = 1'b1;
            end
            porm_pkg::ST_SEL_READ:
            begin
                rd_en = 1'b1;
            end
            porm_pkg::ST_SEL_LAST, porm_pkg::ST_SEL_RESOLVE:
            begin
                in_ready = 1'b0;
            end
            porm_pkg::ST_FINISH:
            begin
                load_out = !out_valid_reg || region.ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign pins.ready = in_ready;

    // Accumulation of boxes, net count, wirelength and flags.
    always_comb
    begin
        excl_next      = excl_reg;
        full_next      = full_reg;
        net_count_next = net_count_reg;
        hpwl_next      = hpwl_reg;
        empty_next     = empty_reg;
        ovf_next       = ovf_reg;
        if (accept)
        begin
            if (close_net)
            begin
                excl_next = porm_pkg::BOX_EMPTY;
                full_next = porm_pkg::BOX_EMPTY;
                hpwl_next = hpwl_sum[porm_pkg::HPWL_W] ? '1 : hpwl_sum[porm_pkg::HPWL_W-1:0];
                // A box without pins keeps its minimum above its maximum.
                if (excl_pin.xmin > excl_pin.xmax)
                begin
                    empty_next = 1'b1;
                end
                if (room)
                begin
                    net_count_next = net_count_reg + porm_pkg::cnt_t'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            else
            begin
                excl_next = excl_pin;
                full_next = full_pin;
            end
        end
        if (load_out)
        begin
            net_count_next = '0;
            hpwl_next      = '0;
            empty_next     = 1'b0;
            ovf_next       = 1'b0;
        end
    end

    // Radix selection: one bit per pass, four ranks tracked on two read streams.
    always_comb
    begin
        porm_pkg::coord_t lo_v;
        porm_pkg::coord_t hi_v;
        porm_pkg::rank_t  hit_lo;
        porm_pkg::rank_t  hit_hi;

        rd_idx_next = rd_idx_reg;
        bit_next    = bit_reg;
        lo_v        = '0;
        hi_v        = '0;
        hit_lo      = '0;
        hit_hi      = '0;
        for (int s = 0; s < porm_pkg::NUM_SEL; s++)
        begin
            prefix_next[s] = prefix_reg[s];
            rank_next[s]   = rank_reg[s];
            count_next[s]  = count_reg[s];
        end

        if (state_reg == porm_pkg::ST_SEL_READ)
        begin
            rd_idx_next = last_row ? '0 : rd_idx_reg + porm_pkg::cnt_t'(1);
        end

        // Count stored bounds that share the decided prefix and have a zero here.
        if (rd_valid_reg)
        begin
            for (int s = 0; s < porm_pkg::NUM_SEL; s++)
            begin
                if (s >= porm_pkg::SEL_Y_LO)
                begin
                    lo_v = y_rd_row[porm_pkg::COORD_BITS-1:0];
                    hi_v = y_rd_row[porm_pkg::ROW_W-1:porm_pkg::COORD_BITS];
                end
                else
                begin
                    lo_v = x_rd_row[porm_pkg::COORD_BITS-1:0];
                    hi_v = x_rd_row[porm_pkg::ROW_W-1:porm_pkg::COORD_BITS];
                end
                hit_lo = porm_pkg::rank_t'(((lo_v ^ prefix_reg[s]) & high_m) == '0
                                           && (lo_v & bit_m) == '0);
                hit_hi = porm_pkg::rank_t'(((hi_v ^ prefix_reg[s]) & high_m) == '0
                                           && (hi_v & bit_m) == '0);
                count_next[s] = count_reg[s] + hit_lo + hit_hi;
            end
        end

        // Decide the bit: rank beyond the zero group means a one here.
        if (state_reg == porm_pkg::ST_SEL_RESOLVE)
        begin
            for (int s = 0; s < porm_pkg::NUM_SEL; s++)
            begin
                if (rank_reg[s] >= count_reg[s])
                begin
                    prefix_next[s] = prefix_reg[s] | bit_m;
                    rank_next[s]   = rank_reg[s] - count_reg[s];
                end
                count_next[s] = '0;
            end
            if (bit_reg != '0)
            begin
                bit_next = bit_reg - porm_pkg::bit_idx_t'(1);
            end
        end

        // Start of selection once the last net is closed.
        if (accept && pins.last_net)
        begin
            rd_idx_next = '0;
            bit_next    = porm_pkg::bit_idx_t'(porm_pkg::COORD_BITS - 1);
            for (int s = 0; s < porm_pkg::NUM_SEL; s++)
            begin
                prefix_next[s] = '0;
                count_next[s]  = '0;
            end
            rank_next[porm_pkg::SEL_X_LO] = {1'b0, net_count_next} - porm_pkg::rank_t'(1);
            rank_next[porm_pkg::SEL_X_HI] = {1'b0, net_count_next};
            rank_next[porm_pkg::SEL_Y_LO] = {1'b0, net_count_next} - porm_pkg::rank_t'(1);
            rank_next[porm_pkg::SEL_Y_HI] = {1'b0, net_count_next};
        end
    end

    // Output word handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (region.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= porm_pkg::ST_COLLECT;
            excl_reg      <= porm_pkg::BOX_EMPTY;
            full_reg      <= porm_pkg::BOX_EMPTY;
            net_count_reg <= '0;
            hpwl_reg      <= '0;
            empty_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            rd_idx_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            excl_reg      <= excl_next;
            full_reg      <= full_next;
            net_count_reg <= net_count_next;
            hpwl_reg      <= hpwl_next;
            empty_reg     <= empty_next;
            ovf_reg       <= ovf_next;
            rd_idx_reg    <= rd_idx_next;
            rd_valid_reg  <= rd_en;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Selection payload registers.
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < porm_pkg::NUM_SEL; s++)
        begin
            prefix_reg[s] <= prefix_next[s];
            rank_reg[s]   <= rank_next[s];
            count_reg[s]  <= count_next[s];
        end
    end

    // Region word payload.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            left_reg      <= porm_pkg::to_field(prefix_reg[porm_pkg::SEL_X_LO]);
            right_reg     <= porm_pkg::to_field(prefix_reg[porm_pkg::SEL_X_HI]);
            top_reg       <= porm_pkg::to_field(prefix_reg[porm_pkg::SEL_Y_LO]);
            bottom_reg    <= porm_pkg::to_field(prefix_reg[porm_pkg::SEL_Y_HI]);
            hpwl_out_reg  <= hpwl_reg;
            empty_out_reg <= empty_reg;
            ovf_out_reg   <= ovf_reg;
        end
    end

    assign region.valid          = out_valid_reg;
    assign region.left_bound     = left_reg;
    assign region.right_bound    = right_reg;
    assign region.top_bound      = top_reg;
    assign region.bottom_bound   = bottom_reg;
    assign region.hpwl_total     = hpwl_out_reg;
    assign region.empty_net_seen = empty_out_reg;
    assign region.net_overflow   = ovf_out_reg;

`ifndef SYNTHESIS
    // A store write only happens while a row is free.
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> net_count_reg < porm_pkg::cnt_t'(porm_pkg::MAX_NETS))
        else $error("bound store written beyond its depth");

    // The last net starts the selection and blocks further pins.
    a_last_starts_select: assert property (@(posedge clk) disable iff (!rst_n)
        (pins.valid && pins.ready && pins.last_net)
            |=> (state_reg == porm_pkg::ST_SEL_READ && !pins.ready))
        else $error("selection did not start after the last net");

    // The upper-median ranks stay inside the stored bound list.
    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != porm_pkg::ST_COLLECT)
            |-> (rank_reg[porm_pkg::SEL_X_HI] < {net_count_reg, 1'b0}
                 && rank_reg[porm_pkg::SEL_Y_HI] < {net_count_reg, 1'b0}))
        else $error("selection rank out of range");

    // Loading the region word presents it on the next cycle.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (region.valid && state_reg == porm_pkg::ST_COLLECT))
        else $error("region word not presented after load");
`endif

endmodule

/* sv/porm_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the per-net bound stores; no dependencies.
module porm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
